[src/boids_flocking_steer_defines.svh]
// ---------------------------------------------------------------------------
// Boids steering: assertion macros
// Shorthand for the concurrent checks of the steering block.
// ---------------------------------------------------------------------------
`ifndef BOIDS_FLOCKING_STEER_DEFINES_SVH
`define BOIDS_FLOCKING_STEER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bfs_pkg.sv]
// ---------------------------------------------------------------------------
// Boids steering package
// Beat types, widths, command and register codes, and small helpers.
// ---------------------------------------------------------------------------
package bfs_pkg;

    localparam int MAX_NEIGHBORS = 1024;
    localparam int CNT_W         = 11;
    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_NEIGHBORS < 2047) ? MAX_NEIGHBORS : 2047);

    localparam int SUM_W = 48;   // accumulator and divider dividend width
    localparam int VEC_W = 49;   // signed vector component under normalisation
    localparam int LEN_W = 32;   // divisor and square root width
    localparam int RAD_W = 31;
    localparam int GAIN_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_NEIGHBOR = 2'd1;
    localparam logic [1:0] CMD_FINISH   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALI_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COH_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALI_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COH_GAIN   = 3'd5;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } t_out_beat;

    function automatic logic [SUM_W-1:0] f_mag(input logic [VEC_W-1:0] v);
        logic [VEC_W-1:0] n;
        n = -v;
        return v[VEC_W-1] ? n[SUM_W-1:0] : v[SUM_W-1:0];
    endfunction

    function automatic logic [31:0] f_sat(input logic [33:0] v);
        logic [31:0] r;
        if (!v[33] && (v[32:31] != 2'b00)) begin
            r = 32'h7FFF_FFFF;
        end else if (v[33] && (v[32:31] != 2'b11)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[src/boids_flocking_steer.sv]
// A load beat is handled in the idle state. A neighbour beat out of range
// ends early; one that feeds separation and alignment, and a finish beat,
// use the shared divider, the square root and the bit-per-cycle normalising
// shift.
// One beat is worked on at a time. Synchronous active-low reset restores the
// register defaults and clears own state, sums and counts.
// ---------------------------------------------------------------------------
// Boids flocking steer
// Separation, alignment and cohesion steering for one particle in Q16.16,
// computed by a sequencer driving one multiplier, one divider and one root.
// ---------------------------------------------------------------------------
`include "boids_flocking_steer_defines.svh"

module boids_flocking_steer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bfs_pkg::t_in_beat                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bfs_pkg::t_out_beat                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bfs_pkg::RAD_W-1:0]           i_cfg_data
);

    localparam int SW = bfs_pkg::SUM_W;
    localparam int VW = bfs_pkg::VEC_W;
    localparam int CW = bfs_pkg::CNT_W;

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_DIST_CHK  = 20'h00002,
        S_SQ_MUL    = 20'h00004,
        S_SQ_ACC    = 20'h00008,
        S_SQRT_GO   = 20'h00010,
        S_SQRT_WAIT = 20'h00020,
        S_NB_TAKE   = 20'h00040,
        S_NB_SEP    = 20'h00080,
        S_NB_ALI    = 20'h00100,
        S_UV_INIT   = 20'h00200,
        S_UV_NORM   = 20'h00400,
        S_DIV_GO    = 20'h00800,
        S_DIV_WAIT  = 20'h01000,
        S_UV_DONE   = 20'h02000,
        S_AVG       = 20'h04000,
        S_AVG_GO    = 20'h08000,
        S_AVG_WAIT  = 20'h10000,
        S_G_MUL     = 20'h20000,
        S_G_ACC     = 20'h40000,
        S_EMIT      = 20'h80000
    } t_state;

    typedef enum logic [1:0] {
        J_DIST = 2'd0,
        J_SEP  = 2'd1,
        J_ALI  = 2'd2,
        J_COH  = 2'd3
    } t_job;

    // configuration
    logic [bfs_pkg::RAD_W-1:0]  r_sep_rad, r_ali_rad, r_coh_rad;
    logic [bfs_pkg::GAIN_W-1:0] r_sep_gain, r_ali_gain, r_coh_gain;

    // architectural state
    t_state               r_state, n_state;
    logic [2:0][31:0]     r_own_pos, n_own_pos, r_own_vel, n_own_vel;
    logic [2:0][SW-1:0]   r_sep_sum, n_sep_sum, r_ali_sum, n_ali_sum;
    logic [2:0][SW-1:0]   r_coh_sum, n_coh_sum;
    logic [CW-1:0]        r_sep_cnt, n_sep_cnt, r_ali_cnt, n_ali_cnt;
    logic [CW-1:0]        r_coh_cnt, n_coh_cnt;
    logic                 r_out_valid, n_out_valid;
    bfs_pkg::t_out_beat   r_out, n_out;

    // working registers
    t_job                 r_job, n_job;
    logic                 r_fin, n_fin;
    logic [1:0]           r_idx, n_idx;
    logic [2:0][31:0]     r_p, n_p, r_v, n_v;
    logic [2:0][VW-1:0]   r_vec, n_vec;
    logic [2:0][SW-1:0]   r_mag, n_mag;
    logic [2:0]           r_neg, n_neg;
    logic [63:0]          r_acc, n_acc;
    logic [31:0]          r_len, n_len;
    logic [2:0][17:0]     r_u, n_u;
    logic [2:0][33:0]     r_nv, n_nv;
    logic                 r_take_sep, n_take_sep, r_take_ali, n_take_ali;

    // shared units
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_prod;
    logic                 sqrt_start, sqrt_done;
    logic [31:0]          sqrt_root;
    logic                 div_start, div_busy, div_done;
    logic [SW-1:0]        div_dividend, div_quo;
    logic [31:0]          div_divisor;

    logic                 in_acc, load_acc;
    logic [2:0][31:0]     in_pos, in_vel;
    logic [SW-1:0]        sel_sum, sum_mag, mag_or;
    logic [CW-1:0]        sel_cnt;
    logic [15:0]          sel_gain;
    logic [17:0]          ucur, umag;
    logic [33:0]          rnd;
    logic [17:0]          tmag, term;
    logic [VW-1:0]        qs;
    logic [63:0]          acc_sum;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign load_acc = in_acc && (i_in_data.command == bfs_pkg::CMD_LOAD);
    assign o_in_stall = (r_state != S_IDLE);

    assign in_pos[0] = i_in_data.pos_x;
    assign in_pos[1] = i_in_data.pos_y;
    assign in_pos[2] = i_in_data.pos_z;
    assign in_vel[0] = i_in_data.vel_x;
    assign in_vel[1] = i_in_data.vel_y;
    assign in_vel[2] = i_in_data.vel_z;

    always_comb begin
        unique case (r_job)
            J_SEP: begin
                sel_sum  = r_sep_sum[r_idx];
                sel_cnt  = r_sep_cnt;
                sel_gain = r_sep_gain;
            end
            J_ALI: begin
                sel_sum  = r_ali_sum[r_idx];
                sel_cnt  = r_ali_cnt;
                sel_gain = r_ali_gain;
            end
            J_COH: begin
                sel_sum  = r_coh_sum[r_idx];
                sel_cnt  = r_coh_cnt;
                sel_gain = r_coh_gain;
            end
            J_DIST: begin
                sel_sum  = '0;
                sel_cnt  = '0;
                sel_gain = '0;
            end
        endcase
    end

    assign sum_mag = f_sum_mag(sel_sum);
    assign mag_or  = r_mag[0] | r_mag[1] | r_mag[2];
    assign ucur    = r_u[r_idx];
    assign umag    = ucur[17] ? -ucur : ucur;
    assign acc_sum = r_acc + mul_prod;

    function automatic logic [SW-1:0] f_sum_mag(input logic [SW-1:0] s);
        return s[SW-1] ? -s : s;
    endfunction

    // Negative gain products round towards minus infinity, hence the bias.
    assign rnd  = {1'b0, mul_prod[32:0]} + 34'd65535;
    assign tmag = ucur[17] ? rnd[33:16] : {1'b0, mul_prod[32:16]};
    assign term = ucur[17] ? -tmag : tmag;

    assign qs = sel_sum[SW-1] ? -{1'b0, div_quo} : {1'b0, div_quo};

    always_comb begin
        unique case (r_state)
            S_SQ_MUL: begin
                mul_a = r_mag[r_idx][31:0];
                mul_b = r_mag[r_idx][31:0];
            end
            S_G_MUL: begin
                mul_a = {15'd0, umag[16:0]};
                mul_b = {16'd0, sel_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_start   = (r_state == S_SQRT_GO);
    assign div_start    = (r_state == S_DIV_GO) || (r_state == S_AVG_GO);
    assign div_dividend = (r_state == S_DIV_GO) ? {r_mag[r_idx][31:0], 16'd0} : sum_mag;
    assign div_divisor  = (r_state == S_DIV_GO) ? r_len : {21'd0, sel_cnt};

    bfs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    bfs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_acc),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    bfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state    = r_state;
        n_own_pos  = r_own_pos;
        n_own_vel  = r_own_vel;
        n_sep_sum  = r_sep_sum;
        n_ali_sum  = r_ali_sum;
        n_coh_sum  = r_coh_sum;
        n_sep_cnt  = r_sep_cnt;
        n_ali_cnt  = r_ali_cnt;
        n_coh_cnt  = r_coh_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out      = r_out;
        n_job      = r_job;
        n_fin      = r_fin;
        n_idx      = r_idx;
        n_p        = r_p;
        n_v        = r_v;
        n_vec      = r_vec;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_len      = r_len;
        n_u        = r_u;
        n_nv       = r_nv;
        n_take_sep = r_take_sep;
        n_take_ali = r_take_ali;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.command)
                        bfs_pkg::CMD_LOAD: begin
                            n_own_pos = in_pos;
                            n_own_vel = in_vel;
                            n_sep_sum = '0;
                            n_ali_sum = '0;
                            n_coh_sum = '0;
                            n_sep_cnt = '0;
                            n_ali_cnt = '0;
                            n_coh_cnt = '0;
                        end
                        bfs_pkg::CMD_NEIGHBOR: begin
                            n_p   = in_pos;
                            n_v   = in_vel;
                            n_fin = 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                n_vec[i] = {{17{in_pos[i][31]}}, in_pos[i]}
                                         - {{17{r_own_pos[i][31]}}, r_own_pos[i]};
                            end
                            n_state = S_DIST_CHK;
                        end
                        bfs_pkg::CMD_FINISH: begin
                            n_fin = 1'b1;
                            n_job = J_SEP;
                            for (int i = 0; i < 3; i++) begin
                                n_nv[i] = {{2{r_own_vel[i][31]}}, r_own_vel[i]};
                            end
                            n_state = S_AVG;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIST_CHK: begin
                for (int i = 0; i < 3; i++) begin
                    n_mag[i] = bfs_pkg::f_mag(r_vec[i]);
                end
                n_acc = '0;
                n_idx = 2'd0;
                n_job = J_DIST;
                // Any offset of 2^31 or more puts the neighbour beyond every radius.
                if ((n_mag[0][SW-1:31] | n_mag[1][SW-1:31] | n_mag[2][SW-1:31]) != '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL: begin
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                n_acc = acc_sum;
                if (r_idx == 2'd2) begin
                    if ((r_job == J_DIST) && (acc_sum == 64'd0)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SQRT_GO;
                    end
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_GO: begin
                n_state = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_len = sqrt_root;
                    n_idx = 2'd0;
                    n_state = (r_job == J_DIST) ? S_NB_TAKE : S_DIV_GO;
                end
            end
            S_NB_TAKE: begin
                n_take_sep = (r_len < {1'b0, r_sep_rad}) && (r_sep_cnt < bfs_pkg::COUNT_CAP);
                n_take_ali = (r_len < {1'b0, r_ali_rad}) && (r_ali_cnt < bfs_pkg::COUNT_CAP);
                if ((r_len < {1'b0, r_coh_rad}) && (r_coh_cnt < bfs_pkg::COUNT_CAP)) begin
                    for (int i = 0; i < 3; i++) begin
                        n_coh_sum[i] = r_coh_sum[i] + {{16{r_p[i][31]}}, r_p[i]};
                    end
                    n_coh_cnt = r_coh_cnt + CW'(1);
                end
                n_state = S_NB_SEP;
            end
            S_NB_SEP: begin
                if (r_take_sep) begin
                    // Separation points from the neighbour back towards self.
                    for (int i = 0; i < 3; i++) begin
                        n_vec[i] = -r_vec[i];
                    end
                    n_job   = J_SEP;
                    n_state = S_UV_INIT;
                end else begin
                    n_state = S_NB_ALI;
                end
            end
            S_NB_ALI: begin
                if (r_take_ali) begin
                    for (int i = 0; i < 3; i++) begin
                        n_vec[i] = {{17{r_v[i][31]}}, r_v[i]};
                    end
                    n_job   = J_ALI;
                    n_state = S_UV_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UV_INIT: begin
                for (int i = 0; i < 3; i++) begin
                    n_mag[i] = bfs_pkg::f_mag(r_vec[i]);
                    n_neg[i] = r_vec[i][VW-1];
                end
                if ((r_vec[0] | r_vec[1] | r_vec[2]) == '0) begin
                    n_u     = '0;
                    n_state = S_UV_DONE;
                end else begin
                    n_state = S_UV_NORM;
                end
            end
            S_UV_NORM: begin
                // One bit per cycle until the largest magnitude sits in [2^30, 2^31).
                if (mag_or[SW-1:31] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_mag[i] = r_mag[i] >> 1;
                    end
                end else if (mag_or[SW-1:30] == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_mag[i] = r_mag[i] << 1;
                    end
                end else begin
                    n_acc   = '0;
                    n_idx   = 2'd0;
                    n_state = S_SQ_MUL;
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_u[r_idx] = r_neg[r_idx] ? -{1'b0, div_quo[16:0]} : {1'b0, div_quo[16:0]};
                    if (r_idx == 2'd2) begin
                        n_state = S_UV_DONE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_UV_DONE: begin
                n_idx = 2'd0;
                if (r_fin) begin
                    n_state = S_G_MUL;
                end else if (r_job == J_SEP) begin
                    for (int i = 0; i < 3; i++) begin
                        n_sep_sum[i] = r_sep_sum[i] + {{30{r_u[i][17]}}, r_u[i]};
                    end
                    n_sep_cnt = r_sep_cnt + CW'(1);
                    n_state   = S_NB_ALI;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        n_ali_sum[i] = r_ali_sum[i] + {{30{r_u[i][17]}}, r_u[i]};
                    end
                    n_ali_cnt = r_ali_cnt + CW'(1);
                    n_state   = S_IDLE;
                end
            end
            S_AVG: begin
                n_idx = 2'd0;
                if (sel_cnt == '0) begin
                    n_vec   = '0;
                    n_state = S_UV_INIT;
                end else begin
                    n_state = S_AVG_GO;
                end
            end
            S_AVG_GO: begin
                n_state = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (div_done) begin
                    if (r_job == J_COH) begin
                        n_vec[r_idx] = qs - {{17{r_own_pos[r_idx][31]}}, r_own_pos[r_idx]};
                    end else begin
                        n_vec[r_idx] = qs;
                    end
                    if (r_idx == 2'd2) begin
                        n_state = S_UV_INIT;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_AVG_GO;
                    end
                end
            end
            S_G_MUL: begin
                n_state = S_G_ACC;
            end
            S_G_ACC: begin
                n_nv[r_idx] = r_nv[r_idx] + {{16{term[17]}}, term};
                if (r_idx == 2'd2) begin
                    n_idx = 2'd0;
                    unique case (r_job)
                        J_SEP: begin
                            n_job   = J_ALI;
                            n_state = S_AVG;
                        end
                        J_ALI: begin
                            n_job   = J_COH;
                            n_state = S_AVG;
                        end
                        J_COH, J_DIST: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_G_MUL;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    for (int i = 0; i < 3; i++) begin
                        n_own_vel[i] = bfs_pkg::f_sat(r_nv[i]);
                    end
                    n_out.new_vel_x = n_own_vel[0];
                    n_out.new_vel_y = n_own_vel[1];
                    n_out.new_vel_z = n_own_vel[2];
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_own_pos   <= '0;
            r_own_vel   <= '0;
            r_sep_sum   <= '0;
            r_ali_sum   <= '0;
            r_coh_sum   <= '0;
            r_sep_cnt   <= '0;
            r_ali_cnt   <= '0;
            r_coh_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_sep_rad   <= 31'd5242880;
            r_ali_rad   <= 31'd6553600;
            r_coh_rad   <= 31'd6553600;
            r_sep_gain  <= 16'd655;
            r_ali_gain  <= 16'd983;
            r_coh_gain  <= 16'd983;
        end else begin
            r_state     <= n_state;
            r_own_pos   <= n_own_pos;
            r_own_vel   <= n_own_vel;
            r_sep_sum   <= n_sep_sum;
            r_ali_sum   <= n_ali_sum;
            r_coh_sum   <= n_coh_sum;
            r_sep_cnt   <= n_sep_cnt;
            r_ali_cnt   <= n_ali_cnt;
            r_coh_cnt   <= n_coh_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bfs_pkg::CFG_SEP_RADIUS: r_sep_rad  <= i_cfg_data;
                    bfs_pkg::CFG_ALI_RADIUS: r_ali_rad  <= i_cfg_data;
                    bfs_pkg::CFG_COH_RADIUS: r_coh_rad  <= i_cfg_data;
                    bfs_pkg::CFG_SEP_GAIN:   r_sep_gain <= i_cfg_data[15:0];
                    bfs_pkg::CFG_ALI_GAIN:   r_ali_gain <= i_cfg_data[15:0];
                    bfs_pkg::CFG_COH_GAIN:   r_coh_gain <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_job      <= n_job;
        r_fin      <= n_fin;
        r_idx      <= n_idx;
        r_p        <= n_p;
        r_v        <= n_v;
        r_vec      <= n_vec;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_acc      <= n_acc;
        r_len      <= n_len;
        r_u        <= n_u;
        r_nv       <= n_nv;
        r_take_sep <= n_take_sep;
        r_take_ali <= n_take_ali;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BFS_ASSERT_SAME(a_div_free, i_clk, i_rst_n, div_start, !div_busy, "divider restarted while busy")
    `BFS_ASSERT_NEXT(a_vel_hold, i_clk, i_rst_n, (r_state != S_EMIT) && !load_acc, $stable(r_own_vel), "own velocity changed outside load or emit")
    `BFS_ASSERT_NEXT(a_out_src, i_clk, i_rst_n, !r_out_valid && (r_state != S_EMIT), !r_out_valid, "result beat raised outside the emit step")

endmodule

[src/bfs_mul.sv]
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 product with a registered result.
// ---------------------------------------------------------------------------
module bfs_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[src/bfs_sqrt.sv]
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module bfs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_radicand,
    output logic                       o_done,
    output logic [bfs_pkg::LEN_W-1:0]  o_root
);

    logic [63:0] r_x, r_r, r_b;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] trial;

    assign trial = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'd31)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_radicand;
            r_r   <= 64'd0;
            r_b   <= 64'd1 << 62;
            r_cnt <= 5'd0;
        end else if (r_busy) begin
            if (r_x >= trial) begin
                r_x <= r_x - trial;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b   <= r_b >> 2;
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[bfs_pkg::LEN_W-1:0];

endmodule

[src/bfs_div.sv]
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of a 48-bit dividend by a 32-bit divisor, one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
module bfs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bfs_pkg::SUM_W-1:0]  i_dividend,
    input  logic [bfs_pkg::LEN_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [bfs_pkg::SUM_W-1:0]  o_quotient
);

    localparam int N = bfs_pkg::SUM_W;
    localparam int D = bfs_pkg::LEN_W;

    logic [D-1:0] r_rem, r_dvs;
    logic [N-1:0] r_quo;
    logic [5:0]   r_cnt;
    logic         r_busy, r_done;
    logic [D:0]   partial;
    logic         last;

    assign partial = {r_rem, r_quo[N-1]};
    assign last    = (r_cnt == 6'(N - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
            r_cnt <= 6'd0;
        end else if (r_busy) begin
            if (partial >= {1'b0, r_dvs}) begin
                r_rem <= D'(partial - {1'b0, r_dvs});
                r_quo <= {r_quo[N-2:0], 1'b1};
            end else begin
                r_rem <= partial[D-1:0];
                r_quo <= {r_quo[N-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[tb/boids_flocking_steer_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Boids steering testbench
// Drives load, neighbour, finish and unused-command beats with random gaps and stalls, works
// out every steered velocity in a behavioural predictor and compares each
// output beat field by field against the oldest pending expectation.
// ---------------------------------------------------------------------------
module boids_flocking_steer_tb;
    import bfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 1500;
    localparam int CAP            = (MAX_NEIGHBORS < 2047) ? MAX_NEIGHBORS : 2047;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_data;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [RAD_W-1:0]     cfg_data;

    boids_flocking_steer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state, mirroring the block's registers.
    longint unsigned sep_rad, ali_rad, coh_rad, sep_gain, ali_gain, coh_gain;
    longint own_pos[3], own_vel[3], sep_sum[3], ali_sum[3], coh_sum[3];
    int     sep_cnt, ali_cnt, coh_cnt;

    t_in_beat  pending_beats[$];
    t_out_beat steered_vels[$];
    int errors;
    int beats_sent;
    int vels_seen;
    int idle_cycles;
    bit hold_out;
    bit drv_pause;

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic unit_of(input longint c[3], output longint u[3]);
        longint unsigned m[3], mx, s, len;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = abs64(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        len = root64(s);
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'((m[i] << 16) / len);
            if (c[i] < 0) u[i] = -u[i];
        end
    endtask

    function automatic longint floor_q16(longint p);
        return p >>> 16;
    endfunction

    task automatic steer_predict(input t_in_beat b);
        longint p[3], v[3], diff[3], u[3], away[3];
        longint sa[3], aa[3], ca[3], us[3], ua[3], uc[3], nv;
        longint unsigned s, d;
        bit far_off;
        t_out_beat o;
        p = '{longint'(b.pos_x), longint'(b.pos_y), longint'(b.pos_z)};
        v = '{longint'(b.vel_x), longint'(b.vel_y), longint'(b.vel_z)};
        case (b.command)
            CMD_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    own_pos[i] = p[i];
                    own_vel[i] = v[i];
                    sep_sum[i] = 0;
                    ali_sum[i] = 0;
                    coh_sum[i] = 0;
                end
                sep_cnt = 0;
                ali_cnt = 0;
                coh_cnt = 0;
            end
            CMD_NEIGHBOR: begin
                far_off = 0;
                s = 0;
                for (int i = 0; i < 3; i++) begin
                    diff[i] = p[i] - own_pos[i];
                    if (abs64(diff[i]) >= (64'd1 << 31)) far_off = 1;
                end
                if (!far_off) begin
                    for (int i = 0; i < 3; i++) s += abs64(diff[i]) * abs64(diff[i]);
                end
                if (!far_off && s != 0) begin
                    d = root64(s);
                    if (d < sep_rad && sep_cnt < CAP) begin
                        for (int i = 0; i < 3; i++) away[i] = -diff[i];
                        unit_of(away, u);
                        for (int i = 0; i < 3; i++) sep_sum[i] += u[i];
                        sep_cnt++;
                    end
                    if (d < ali_rad && ali_cnt < CAP) begin
                        unit_of(v, u);
                        for (int i = 0; i < 3; i++) ali_sum[i] += u[i];
                        ali_cnt++;
                    end
                    if (d < coh_rad && coh_cnt < CAP) begin
                        for (int i = 0; i < 3; i++) coh_sum[i] += p[i];
                        coh_cnt++;
                    end
                end
            end
            CMD_FINISH: begin
                for (int i = 0; i < 3; i++) begin
                    sa[i] = sep_cnt ? sep_sum[i] / sep_cnt : 0;
                    aa[i] = ali_cnt ? ali_sum[i] / ali_cnt : 0;
                    ca[i] = coh_cnt ? coh_sum[i] / coh_cnt - own_pos[i] : 0;
                end
                unit_of(sa, us);
                unit_of(aa, ua);
                unit_of(ca, uc);
                for (int i = 0; i < 3; i++) begin
                    nv = own_vel[i] + floor_q16(us[i] * longint'(sep_gain))
                        + floor_q16(ua[i] * longint'(ali_gain))
                        + floor_q16(uc[i] * longint'(coh_gain));
                    if (nv > 64'sh7FFF_FFFF) nv = 64'sh7FFF_FFFF;
                    if (nv < -64'sh8000_0000) nv = -64'sh8000_0000;
                    own_vel[i] = nv;
                end
                o.new_vel_x = own_vel[0][31:0];
                o.new_vel_y = own_vel[1][31:0];
                o.new_vel_z = own_vel[2][31:0];
                steered_vels.push_back(o);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Sender: one beat at a time from the pending queue, random gap before each.
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (in_valid && !in_stall) begin
            // Previous beat is taken at the coming edge; this is handled at posedge.
        end
    end

    // Acceptance is evaluated at posedge; the next beat is driven on the negedge after.
    bit in_fire;
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_valid && !in_stall;
        if (i_rst_n && in_valid && !in_stall) begin
            steer_predict(in_data);
            beats_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire || !in_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (!drv_pause && pending_beats.size() > 0) begin
                    in_data  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall per beat, plus an optional long hold-off.
    int stall_left;
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            vels_seen++;
            if (steered_vels.size() == 0) begin
                $display("unexpected output beat at %0t", $time);
                errors++;
            end else begin
                t_out_beat w;
                w = steered_vels.pop_front();
                if (out_data.new_vel_x !== w.new_vel_x)
                    report_mismatch("new_vel_x", out_data.new_vel_x, w.new_vel_x);
                if (out_data.new_vel_y !== w.new_vel_y)
                    report_mismatch("new_vel_y", out_data.new_vel_y, w.new_vel_y);
                if (out_data.new_vel_z !== w.new_vel_z)
                    report_mismatch("new_vel_z", out_data.new_vel_z, w.new_vel_z);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_out) begin
            out_stall  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (out_valid && !out_stall) begin
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[RAD_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SEP_RADIUS: sep_rad  = val & 64'h7FFF_FFFF;
            CFG_ALI_RADIUS: ali_rad  = val & 64'h7FFF_FFFF;
            CFG_COH_RADIUS: coh_rad  = val & 64'h7FFF_FFFF;
            CFG_SEP_GAIN:   sep_gain = val & 64'hFFFF;
            CFG_ALI_GAIN:   ali_gain = val & 64'hFFFF;
            CFG_COH_GAIN:   coh_gain = val & 64'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || steered_vels.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_beat make_beat(input logic [1:0] cmd, input longint px,
                                           input longint py, input longint pz);
        t_in_beat b;
        b.command = cmd;
        b.pos_x = px[31:0];
        b.pos_y = py[31:0];
        b.pos_z = pz[31:0];
        b.vel_x = $urandom();
        b.vel_y = $urandom();
        b.vel_z = $urandom();
        return b;
    endfunction

    // One flock: self, a few neighbours mostly near it, now and then an unused command, then one or two finishes.
    task automatic queue_flock(input int n_nb);
        longint sx, sy, sz, spread;
        t_in_beat b;
        spread = 64'd1 << $urandom_range(14, 24);
        sx = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        sy = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        sz = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        pending_beats.push_back(make_beat(CMD_LOAD, sx, sy, sz));
        for (int k = 0; k < n_nb; k++) begin
            case ($urandom_range(0, 9))
                0: b = make_beat(CMD_NEIGHBOR, sx, sy, sz);
                1: b = make_beat(CMD_NEIGHBOR, rnd_word(), rnd_word(), rnd_word());
                default: b = make_beat(CMD_NEIGHBOR,
                    sx + $signed($urandom_range(0, 2 * spread)) - spread,
                    sy + $signed($urandom_range(0, 2 * spread)) - spread,
                    sz + $signed($urandom_range(0, 2 * spread)) - spread);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                b.vel_x = 0;
                b.vel_y = 0;
                b.vel_z = 0;
            end
            pending_beats.push_back(b);
        end
        if ($urandom_range(0, 15) == 0) begin
            b = make_beat(2'd3, rnd_word(), rnd_word(), rnd_word());
            pending_beats.push_back(b);
        end
        pending_beats.push_back(make_beat(CMD_FINISH, 0, 0, 0));
        if ($urandom_range(0, 4) == 0)
            pending_beats.push_back(make_beat(CMD_FINISH, 0, 0, 0));
    endtask

    initial begin
        t_in_beat b;
        int hold_cycles;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b1;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_SEP_RADIUS;
        cfg_data  = '0;
        errors = 0;
        beats_sent = 0;
        vels_seen = 0;
        hold_out = 0;
        drv_pause = 0;
        sep_rad = 5242880; ali_rad = 6553600; coh_rad = 6553600;
        sep_gain = 655; ali_gain = 983; coh_gain = 983;
        for (int i = 0; i < 3; i++) begin
            own_pos[i] = 0; own_vel[i] = 0;
            sep_sum[i] = 0; ali_sum[i] = 0; coh_sum[i] = 0;
        end
        sep_cnt = 0; ali_cnt = 0; coh_cnt = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: finish before any load, field extremes, coincident and far neighbours.
        pending_beats.push_back(make_beat(CMD_FINISH, 0, 0, 0));
        b = make_beat(CMD_LOAD, 0, 0, 0);
        b.vel_x = 32'h7FFF_FFFF; b.vel_y = 32'h8000_0000; b.vel_z = 0;
        pending_beats.push_back(b);
        pending_beats.push_back(make_beat(CMD_NEIGHBOR, 0, 0, 0));
        pending_beats.push_back(make_beat(CMD_NEIGHBOR, 32'h7FFF_FFFF, 0, 0));
        pending_beats.push_back(make_beat(CMD_NEIGHBOR, 65536, 0, 0));
        b = make_beat(CMD_NEIGHBOR, 0, -65536, 131072);
        b.vel_x = 0; b.vel_y = 0; b.vel_z = 0;
        pending_beats.push_back(b);
        pending_beats.push_back(make_beat(CMD_FINISH, 0, 0, 0));
        pending_beats.push_back(make_beat(CMD_FINISH, 0, 0, 0));
        b = make_beat(CMD_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        b.vel_x = 32'hFFFF_FFFF; b.vel_y = 32'h0000_0001; b.vel_z = 32'h8000_0000;
        pending_beats.push_back(b);
        pending_beats.push_back(make_beat(CMD_NEIGHBOR, 32'sh8000_0000, 32'sh7FFF_0000, 0));
        pending_beats.push_back(make_beat(CMD_NEIGHBOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_beats.push_back(make_beat(2'd3, 1, 2, 3));
        pending_beats.push_back(make_beat(CMD_FINISH, 0, 0, 0));
        drain();

        // Extreme settings: maximum radii and gains.
        write_reg(CFG_SEP_RADIUS, 64'h7FFF_FFFF);
        write_reg(CFG_ALI_RADIUS, 64'h7FFF_FFFF);
        write_reg(CFG_COH_RADIUS, 64'h7FFF_FFFF);
        write_reg(CFG_SEP_GAIN, 16'hFFFF);
        write_reg(CFG_ALI_GAIN, 16'hFFFF);
        write_reg(CFG_COH_GAIN, 16'hFFFF);
        while (beats_sent + pending_beats.size() < 150) queue_flock($urandom_range(1, 6));
        // Long receiver hold-off while the sender keeps offering beats.
        hold_out = 1;
        hold_cycles = 0;
        while (hold_cycles < 3000) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        hold_out = 0;
        drain();

        // Zero radii and gains: nothing counts, velocity passes through.
        write_reg(CFG_SEP_RADIUS, 0);
        write_reg(CFG_ALI_RADIUS, 0);
        write_reg(CFG_COH_RADIUS, 0);
        write_reg(CFG_SEP_GAIN, 0);
        write_reg(CFG_ALI_GAIN, 0);
        write_reg(CFG_COH_GAIN, 0);
        for (int k = 0; k < 8; k++) queue_flock($urandom_range(0, 3));
        drain();

        // Random settings in several phases, each followed by a full drain.
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_SEP_RADIUS, $urandom_range(0, 32'h0100_0000));
            write_reg(CFG_ALI_RADIUS, $urandom_range(0, 32'h0200_0000));
            write_reg(CFG_COH_RADIUS, $urandom_range(0, 32'h7FFF_FFFF));
            write_reg(CFG_SEP_GAIN, $urandom_range(0, 16'hFFFF));
            write_reg(CFG_ALI_GAIN, $urandom_range(0, 16'hFFFF));
            write_reg(CFG_COH_GAIN, $urandom_range(0, 16'hFFFF));
            for (int k = 0; k < 25; k++) queue_flock($urandom_range(0, 6));
            drain();
        end

        $display("Covered %0d input beats and %0d steered velocities over several",
                 beats_sent, vels_seen);
        $display("radius and gain settings, including extremes and stalls.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
